// ===== hdl/cnmt_pkg.sv =====
`timescale 1ns / 1ps

package cnmt_pkg;

    typedef enum logic [1:0] {
        KIND_CREATE = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LIST   = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_CREATED   = 3'd0,
        STATUS_DELETED   = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_PRESENT   = 3'd3,
        STATUS_FULL      = 3'd4,
        STATUS_EMPTY     = 3'd5,
        STATUS_LISTED    = 3'd6
    } status_t;

    localparam int NAME_W  = 64;
    localparam int INDEX_W = 4;
    localparam int HELD_W  = 5;

endpackage

// ===== hdl/cnmt_item_if.sv =====
`timescale 1ns / 1ps

interface cnmt_item_if
    import cnmt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [NAME_W-1:0] file_name;

    modport source (output valid, output kind, output file_name, input ready);
    modport sink (input valid, input kind, input file_name, output ready);
endinterface

// ===== hdl/cnmt_result_if.sv =====
`timescale 1ns / 1ps

interface cnmt_result_if
    import cnmt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [INDEX_W-1:0] entry_index;
    logic [NAME_W-1:0]  entry_name;
    logic [HELD_W-1:0]  entries_held;
    logic               last;

    modport source (
        output valid, output status, output entry_index, output entry_name,
        output entries_held, output last, input ready
    );
    modport sink (
        input valid, input status, input entry_index, input entry_name,
        input entries_held, input last, output ready
    );
endinterface

// ===== hdl/cnmt_store.sv =====
`timescale 1ns / 1ps

module cnmt_store #(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 64,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic [IW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [ENTRIES];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cnmt_seq.sv =====
`timescale 1ns / 1ps

module cnmt_seq
    import cnmt_pkg::*;
#(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 64,
    localparam int IW     = $clog2(ENTRIES),
    localparam int CW     = $clog2(ENTRIES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    cnmt_item_if.sink        item,
    cnmt_result_if.source    result,
    output logic             wr_en,
    output logic [IW-1:0]    wr_addr,
    output logic [KEY_W-1:0] wr_data,
    output logic [IW-1:0]    rd_addr,
    input  logic [KEY_W-1:0] rd_data
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_READ     = 6'b000010,
        ST_EVAL     = 6'b000100,
        ST_SH_READ  = 6'b001000,
        ST_SH_WRITE = 6'b010000,
        ST_EMIT     = 6'b100000
    } seq_state_t;

    seq_state_t       state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IW-1:0]    idx_reg, idx_next;
    logic [IW-1:0]    at_reg, at_next;
    logic [CW-1:0]    count_reg, count_next;
    status_t          status_reg, status_next;
    logic [IW-1:0]    oidx_reg, oidx_next;
    logic [KEY_W-1:0] oname_reg, oname_next;
    logic             last_reg, last_next;

    logic [CW-1:0]    idx_plus;
    logic             at_end;
    logic             hit;
    kind_t            kind_in;
    logic [KEY_W-1:0] key_in;

    assign idx_plus = CW'(idx_reg) + CW'(1);
    assign at_end   = (idx_plus >= count_reg);
    assign hit      = (rd_data == key_reg);
    assign kind_in  = kind_t'(item.kind);
    assign key_in   = item.file_name[KEY_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        at_next     = at_reg;
        count_next  = count_reg;
        status_next = status_reg;
        oidx_next   = oidx_reg;
        oname_next  = oname_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        wr_addr     = count_reg[IW-1:0];
        wr_data     = key_in;
        rd_addr     = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    kind_next  = kind_in;
                    key_next   = key_in;
                    idx_next   = '0;
                    oidx_next  = '0;
                    oname_next = '0;
                    last_next  = 1'b1;
                    if (kind_in == KIND_CREATE)
                    begin
                        state_next = ST_EMIT;
                        if (count_reg >= CW'(ENTRIES))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            status_next = STATUS_CREATED;
                            oidx_next   = count_reg[IW-1:0];
                            count_next  = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next  = ST_EMIT;
                        status_next = (kind_in == KIND_LIST) ? STATUS_EMPTY
                                                             : STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (kind_reg == KIND_LIST)
                begin
                    status_next = STATUS_LISTED;
                    oidx_next   = idx_reg;
                    oname_next  = rd_data;
                    last_next   = at_end;
                    state_next  = ST_EMIT;
                end
                else if (hit)
                begin
                    oidx_next = idx_reg;
                    if (kind_reg == KIND_SEARCH)
                    begin
                        status_next = STATUS_PRESENT;
                        state_next  = ST_EMIT;
                    end
                    else if (!at_end)
                    begin
                        at_next    = idx_reg;
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_SH_READ;
                    end
                    else
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = STATUS_DELETED;
                        state_next  = ST_EMIT;
                    end
                end
                else if (at_end)
                begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_READ;
                end
            end
            ST_SH_READ:
            begin
                state_next = ST_SH_WRITE;
            end
            ST_SH_WRITE:
            begin
                // move one entry down over the gap
                wr_en   = 1'b1;
                wr_addr = idx_reg - IW'(1);
                wr_data = rd_data;
                if (!at_end)
                begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_SH_READ;
                end
                else
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = STATUS_DELETED;
                    oidx_next   = at_reg;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (result.ready)
                begin
                    if (kind_reg == KIND_LIST && !last_reg)
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        at_reg     <= at_next;
        status_reg <= status_next;
        oidx_reg   <= oidx_next;
        oname_reg  <= oname_next;
        last_reg   <= last_next;
    end

    assign item.ready          = (state_reg == ST_IDLE);
    assign result.valid        = (state_reg == ST_EMIT);
    assign result.status       = status_reg;
    assign result.entry_index  = INDEX_W'(oidx_reg);
    assign result.entry_name   = NAME_W'(oname_reg);
    assign result.entries_held = HELD_W'(count_reg);
    assign result.last         = last_reg;

endmodule

// ===== hdl/compacting_name_table_core.sv =====
`timescale 1ns / 1ps
// create, or any request on an empty table: result valid in the cycle after the transfer
// search, delete: read, compare per entry; read, write per moved entry; then result
// list: read, evaluate and result state per entry, plus output wait
// one item at a time; the next transfer can be taken in the cycle after the last result transfer
// async reset empties the table; store contents are left as they are

module compacting_name_table_core #(
    parameter int ENTRIES    = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    cnmt_item_if.sink     item,
    cnmt_result_if.source result
);

    localparam int KEY_W = 8 * NAME_BYTES;
    localparam int IW    = $clog2(ENTRIES);

    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [IW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;

    cnmt_seq #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .result  (result),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cnmt_store #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ===== hdl/cnmt_checker.sv =====
`timescale 1ns / 1ps

module cnmt_checker
    import cnmt_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [2:0]         status,
    input logic [INDEX_W-1:0] entry_index,
    input logic [NAME_W-1:0]  entry_name,
    input logic [HELD_W-1:0]  entries_held,
    input logic               last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_index) && $stable(entry_name) && $stable(last))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    a_created_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_CREATED
            |-> entry_index == INDEX_W'(entries_held - HELD_W'(1)))
        else $error("created index does not match table size");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY
            |-> entries_held == '0 && last && entry_name == '0)
        else $error("empty list result malformed");

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ENTRIES < 32 |-> entries_held <= HELD_W'(ENTRIES))
        else $error("entry count beyond table size");

endmodule

bind compacting_name_table_core cnmt_checker #(
    .ENTRIES (ENTRIES)
) u_cnmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (result.status),
    .entry_index  (result.entry_index),
    .entry_name   (result.entry_name),
    .entries_held (result.entries_held),
    .last         (result.last)
);

// ===== sim/cnmt_table_checker.sv =====
`timescale 1ns / 1ps

module cnmt_table_checker
    import cnmt_pkg::*;
#(
    parameter int ENTRIES    = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    cnmt_item_if        item,
    cnmt_result_if      result,
    output int unsigned replies_pending,
    output int unsigned mismatches
);

    localparam logic [NAME_W-1:0] KEY_MASK = (NAME_BYTES >= 8) ? {NAME_W{1'b1}}
                                           : ((64'd1 << (8 * NAME_BYTES)) - 64'd1);

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] slot;
        logic [NAME_W-1:0]  name;
        logic [HELD_W-1:0]  held;
        logic               last;
    } table_reply_t;

    logic [NAME_W-1:0] table_names [ENTRIES];
    int unsigned       names_held;
    table_reply_t      awaited_replies [$];
    table_reply_t      want;

    function automatic void queue_reply(status_t st, int unsigned slot, logic [NAME_W-1:0] nm,
                                        bit is_last);
        table_reply_t r;
        r.status = st;
        r.slot   = slot[INDEX_W-1:0];
        r.name   = nm;
        r.held   = names_held[HELD_W-1:0];
        r.last   = is_last;
        awaited_replies.push_back(r);
    endfunction

    function automatic void predict_reply(kind_t op, logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] key;
        int                hit;
        key = raw & KEY_MASK;
        hit = -1;
        for (int i = 0; i < names_held; i++)
        begin
            if (hit < 0 && table_names[i] == key)
                hit = i;
        end
        case (op)
            KIND_CREATE:
            begin
                if (names_held >= ENTRIES)
                    queue_reply(STATUS_FULL, 0, '0, 1'b1);
                else
                begin
                    table_names[names_held] = key;
                    names_held++;
                    queue_reply(STATUS_CREATED, names_held - 1, '0, 1'b1);
                end
            end
            KIND_DELETE:
            begin
                if (hit < 0)
                    queue_reply(STATUS_NOT_FOUND, 0, '0, 1'b1);
                else
                begin
                    for (int i = hit; i + 1 < names_held; i++)
                        table_names[i] = table_names[i + 1];
                    names_held--;
                    queue_reply(STATUS_DELETED, hit, '0, 1'b1);
                end
            end
            KIND_SEARCH:
            begin
                if (hit < 0)
                    queue_reply(STATUS_NOT_FOUND, 0, '0, 1'b1);
                else
                    queue_reply(STATUS_PRESENT, hit, '0, 1'b1);
            end
            default:
            begin
                if (names_held == 0)
                    queue_reply(STATUS_EMPTY, 0, '0, 1'b1);
                else
                begin
                    for (int i = 0; i < names_held; i++)
                        queue_reply(STATUS_LISTED, i, table_names[i], i + 1 == names_held);
                end
            end
        endcase
    endfunction

    function automatic int field_differs(string field, logic [63:0] want_v, logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    // results first, so a result can never match the transfer taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("unexpected result: status %0d, entry_index %0d",
                           result.status, result.entry_index);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    mismatches = mismatches
                        + field_differs("status", 64'(want.status), 64'(result.status))
                        + field_differs("entry_index", 64'(want.slot),
                                        64'(result.entry_index))
                        + field_differs("entry_name", want.name, result.entry_name)
                        + field_differs("entries_held", 64'(want.held),
                                        64'(result.entries_held))
                        + field_differs("last", 64'(want.last), 64'(result.last));
                end
            end
            if (item.valid && item.ready)
                predict_reply(kind_t'(item.kind), item.file_name);
            replies_pending = awaited_replies.size();
        end
    end

endmodule

// ===== sim/compacting_name_table_core_tb.sv =====
`timescale 1ns / 1ps

module compacting_name_table_core_tb;

    import cnmt_pkg::*;

    localparam int ENTRIES         = 16;
    localparam int NAME_BYTES      = 8;
    localparam int RANDOM_ITEMS    = 325;
    localparam int POOL_SIZE       = 12;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 100;
    localparam int QUIET_LIMIT     = 2000;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    bit                idle_on       = 1'b0;
    bit                hold_off_req  = 1'b0;
    bit                hold_off_done = 1'b0;
    int unsigned       quiet_cycles  = 0;
    int unsigned       replies_pending;
    int unsigned       mismatches;
    logic [NAME_W-1:0] name_pool [POOL_SIZE];

    cnmt_item_if   item_ch ();
    cnmt_result_if result_ch ();

    compacting_name_table_core #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    cnmt_table_checker #(
        .ENTRIES    (ENTRIES),
        .NAME_BYTES (NAME_BYTES)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .replies_pending (replies_pending),
        .mismatches      (mismatches)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side: short random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 2) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic offer(input kind_t op, input logic [NAME_W-1:0] nm);
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= op;
        item_ch.file_name <= nm;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            item_ch.valid     <= 1'b0;
            item_ch.kind      <= kind_t'($urandom_range(0, 3));
            item_ch.file_name <= {$urandom, $urandom};
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain_pause();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        wait (replies_pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [NAME_W-1:0] pick_name();
        if ($urandom_range(0, 9) < 8)
            return name_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // even phases mostly fill the table, odd phases mostly empty it
    function automatic kind_t random_kind(int phase);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return KIND_LIST;
        if (roll < 35)
            return KIND_SEARCH;
        if (phase % 2 == 0)
            return (roll < 85) ? KIND_CREATE : KIND_DELETE;
        return (roll < 50) ? KIND_CREATE : KIND_DELETE;
    endfunction

    initial
    begin
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_CREATE;
        item_ch.file_name = '0;
        for (int i = 0; i < POOL_SIZE; i++)
            name_pool[i] = {$urandom, $urandom};
        name_pool[0] = '0;
        name_pool[1] = '1;
        name_pool[3] = name_pool[2] ^ (64'd1 << 63);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // empty table, then fill with duplicates and extremes
        offer(KIND_LIST, '0);
        offer(KIND_SEARCH, '0);
        offer(KIND_DELETE, '0);
        offer(KIND_CREATE, '0);
        offer(KIND_CREATE, '1);
        offer(KIND_CREATE, '0);
        offer(KIND_CREATE, {32{2'b01}});
        offer(KIND_CREATE, {32{2'b10}});
        repeat (ENTRIES - 5) offer(KIND_CREATE, {$urandom, $urandom});
        offer(KIND_CREATE, 64'd1);
        offer(KIND_LIST, '0);
        offer(KIND_SEARCH, '1);
        offer(KIND_SEARCH, 64'h8000_0000_0000_0000);
        offer(KIND_DELETE, '0);
        offer(KIND_LIST, '1);
        drain_pause();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 120)
                hold_off_req = 1'b1;
            if (n == 240)
                drain_pause();
            idle_on = !((n >= 150 && n < 190) || n >= RANDOM_ITEMS - 50);
            offer(random_kind(n / 30), pick_name());
        end

        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && replies_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/cnmt_pkg.sv
hdl/cnmt_item_if.sv
hdl/cnmt_result_if.sv
hdl/cnmt_store.sv
hdl/cnmt_seq.sv
hdl/compacting_name_table_core.sv
hdl/cnmt_checker.sv
sim/cnmt_table_checker.sv
sim/compacting_name_table_core_tb.sv
